// ===== rtl/oht_pkg.sv =====
// ----------------------------------------------------------------------------
// oht_pkg
// shared types and codes of the object handle table
// ----------------------------------------------------------------------------
package oht_pkg;

  localparam int OP_W      = 2;
  localparam int ID_W      = 8;
  localparam int ST_W      = 2;
  localparam int OUT_REF_W = 32;

  // requested operation
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPARAM = 2'd2;
  localparam logic [ST_W-1:0] ST_BADOBJ   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } oht_state_t;

endpackage

// ===== rtl/oht_store.sv =====
// ----------------------------------------------------------------------------
// oht_store
// entry memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module oht_store
  import oht_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 33
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0]                        rd_data,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0]                        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/oht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oht_ctrl
// request sequencer: read entry, decide, write back, register the result
// ----------------------------------------------------------------------------
module oht_ctrl
  import oht_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int REF_WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // request side
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [OP_W-1:0]                             in_op,
  input  logic [ID_W-1:0]                             in_id,
  input  logic [OUT_REF_W-1:0]                        in_ref,
  // entry memory
  output logic                                        mem_rd_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
  input  logic [REF_WIDTH:0]                          mem_rd_data,
  output logic                                        mem_wr_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
  output logic [REF_WIDTH:0]                          mem_wr_data,
  // result side
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ST_W-1:0]                             out_status,
  output logic [ID_W-1:0]                             out_assigned,
  output logic [OUT_REF_W-1:0]                        out_found
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = (NW > ID_W) ? NW : ID_W;
  localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

  oht_state_t state_r, state_nxt;

  logic [OP_W-1:0]      op_r;
  logic [ID_W-1:0]      id_r;
  logic [REF_WIDTH-1:0] ref_r;
  logic [NW-1:0]        next_r, next_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [ID_W-1:0]      assigned_r, assigned_nxt;
  logic [OUT_REF_W-1:0] found_r, found_nxt;

  logic                 accept;
  logic                 finish;
  logic                 entry_live;
  logic                 id_valid;
  logic [REF_WIDTH-1:0] entry_ref;

  assign accept     = in_valid && in_ready;
  assign finish     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign entry_live = mem_rd_data[REF_WIDTH];
  assign entry_ref  = mem_rd_data[REF_WIDTH-1:0];

  // entries at or above the pointer were never handed out, number zero never is
  assign id_valid = (id_r != '0) && (CW'(id_r) < CW'(next_r)) && entry_live;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath decisions
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    mem_rd_en     = accept;
    mem_rd_addr   = IW'(CW'(in_id));
    mem_wr_en     = 1'b0;
    mem_wr_addr   = IW'(next_r);
    mem_wr_data   = {1'b1, ref_r};
    next_nxt      = next_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    assigned_nxt  = assigned_r;
    found_nxt     = found_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      assigned_nxt  = '0;
      found_nxt     = '0;
      case (op_r)
        OP_ADD: begin
          if (ref_r == '0) begin
            status_nxt = ST_BADPARAM;
          end else if (next_r == CAP_N) begin
            status_nxt = ST_FULL;
          end else begin
            mem_wr_en    = 1'b1;
            next_nxt     = next_r + NW'(1);
            assigned_nxt = ID_W'(next_r);
          end
        end
        OP_REMOVE: begin
          if (id_valid) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = IW'(CW'(id_r));
            mem_wr_data = {1'b0, entry_ref};
          end else begin
            status_nxt = ST_BADOBJ;
          end
        end
        OP_GET: begin
          if (id_valid) begin
            found_nxt = OUT_REF_W'(entry_ref);
          end else begin
            status_nxt = ST_BADOBJ;
          end
        end
        default: status_nxt = ST_BADPARAM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_r      <= NW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      id_r  <= in_id;
      ref_r <= REF_WIDTH'(in_ref);
    end
    status_r   <= status_nxt;
    assigned_r <= assigned_nxt;
    found_r    <= found_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_assigned = assigned_r;
  assign out_found    = found_r;

endmodule

// ===== rtl/object_handle_table.sv =====
// ----------------------------------------------------------------------------
// object_handle_table
// maps small object numbers to stored object references (add, remove, get)
// ----------------------------------------------------------------------------
//
//  channel | direction | contents
//  --------+-----------+-----------------------------------------------
//  in_     | slave     | tuser: op; tdata: object_id, object_ref
//  out_    | master    | tdata: status, assigned_id, found_ref
//
//  each request first reads the entry memory, then decides and writes back;
//  the next request is held until that write back, so two requests never
//  touch the same entry at once
//  the next request is taken in the cycle after the previous result is
//  registered, even while that result still waits on out_tready
//  a result held by out_tready low stalls the request behind it in place
//  reset restores the number pointer to one; the memory needs no clearing
//  pass since entries at or above the pointer are known to be unused
//
module object_handle_table
  import oht_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int REF_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic [39:0] in_tdata,   // object_id[7:0], object_ref[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], assigned_id[9:2], found_ref[41:10], zero pad
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // entry memory request lines
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [REF_WIDTH:0]   rd_data;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [REF_WIDTH:0]   wr_data;

  // result fields
  logic [ST_W-1:0]      status;
  logic [ID_W-1:0]      assigned;
  logic [OUT_REF_W-1:0] found;

  // each entry holds a live bit above the stored reference
  oht_ctrl #(
    .CAPACITY  (CAPACITY),
    .REF_WIDTH (REF_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_id        (in_tdata[7:0]),
    .in_ref       (in_tdata[39:8]),
    .mem_rd_en    (rd_en),
    .mem_rd_addr  (rd_addr),
    .mem_rd_data  (rd_data),
    .mem_wr_en    (wr_en),
    .mem_wr_addr  (wr_addr),
    .mem_wr_data  (wr_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (status),
    .out_assigned (assigned),
    .out_found    (found)
  );

  oht_store #(
    .DEPTH  (CAPACITY),
    .DATA_W (REF_WIDTH + 1)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // pack result fields, lowest field first, padded to whole bytes
  assign out_tdata = {6'd0, found, assigned, status};

endmodule

// ===== tb/object_handle_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// object_handle_table_tb
// checks add, remove and get requests against an in-bench model of the table
// ----------------------------------------------------------------------------
module object_handle_table_tb
  import oht_pkg::*;
();

  localparam int TABLE_SIZE = 256;
  localparam int CYCLE_LIMIT = 300000;
  // op code that the block has no name for; it must be rejected
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  // one expected result, fields as they travel on out_tdata
  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [ID_W-1:0]      assigned_id;
    logic [OUT_REF_W-1:0] found_ref;
  } handle_reply_t;

  // in-bench copy of the table: used marks, stored references, number pointer
  class handle_table_scoreboard;
    bit                   live [TABLE_SIZE];
    bit [OUT_REF_W-1:0]   refs [TABLE_SIZE];
    int unsigned          next_number;
    int unsigned          live_count;
    int unsigned          errors;
    handle_reply_t        replies_due [$];

    function new();
      foreach (live[i]) live[i] = 1'b0;
      next_number = 1;
      live_count  = 0;
      errors      = 0;
    endfunction

    // works out the result of an accepted request and updates the table
    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [OUT_REF_W-1:0] obj_ref);
      handle_reply_t r;
      int unsigned   n;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_ADD: begin
          if (obj_ref == '0) begin
            r.status = ST_BADPARAM;
          end else begin
            // scan up from the pointer; freed numbers below it stay unused
            n = next_number;
            while (n < TABLE_SIZE && live[n]) n++;
            if (n < TABLE_SIZE) begin
              live[n]       = 1'b1;
              refs[n]       = obj_ref;
              next_number   = n + 1;
              live_count++;
              r.assigned_id = n[ID_W-1:0];
            end else begin
              r.status = ST_FULL;
            end
          end
        end
        OP_REMOVE: begin
          if (live[id]) begin
            live[id] = 1'b0;
            live_count--;
          end else begin
            r.status = ST_BADOBJ;
          end
        end
        OP_GET: begin
          // a removed entry keeps its reference but must read as invalid
          if (live[id]) r.found_ref = refs[id];
          else r.status = ST_BADOBJ;
        end
        default: r.status = ST_BADPARAM;
      endcase
      replies_due.push_back(r);
    endfunction

    // a number currently in use, or any number when the table is empty
    function logic [ID_W-1:0] pick_live_id();
      int unsigned id;
      if (live_count == 0) return ID_W'($urandom_range(0, TABLE_SIZE - 1));
      do id = $urandom_range(1, next_number - 1); while (!live[id]);
      return id[ID_W-1:0];
    endfunction

    function int unsigned depth();
      return replies_due.size();
    endfunction

    task report(string what, logic [OUT_REF_W-1:0] want, logic [OUT_REF_W-1:0] got);
      errors++;
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    endtask

    task check_result(logic [47:0] word);
      handle_reply_t want;
      handle_reply_t got;
      got.status      = word[1:0];
      got.assigned_id = word[9:2];
      got.found_ref   = word[41:10];
      if (replies_due.size() == 0) begin
        report("result with no request outstanding", '0, word[31:0]);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report("status", OUT_REF_W'(want.status), OUT_REF_W'(got.status));
        if (got.assigned_id !== want.assigned_id)
          report("assigned_id", OUT_REF_W'(want.assigned_id), OUT_REF_W'(got.assigned_id));
        if (got.found_ref !== want.found_ref)
          report("found_ref", want.found_ref, got.found_ref);
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // op[1:0]
  logic [39:0] in_tdata;   // object_id[7:0], object_ref[39:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // status[1:0], assigned_id[9:2], found_ref[41:10], zero pad

  handle_table_scoreboard sb;

  int send_idle_pct;   // chance per cycle that the sender holds back
  int recv_stall_pct;  // chance per cycle that the receiver stalls
  bit hold_off;        // long receiver stall for the back-pressure phase
  int cycles;

  object_handle_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, counted in clock cycles
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side: random stalls, or a solid stall while hold_off is set
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // offers one request from a falling edge and returns at the falling edge
  // after it was taken; tvalid stays high so back-to-back requests need no gap
  task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [OUT_REF_W-1:0] obj_ref);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {obj_ref, id};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, id, obj_ref);
    @(negedge clk);
  endtask

  // mostly well-formed traffic on live numbers, some noise and bad requests;
  // adds are paced so the numbers run out late in the run
  task automatic send_random_request();
    int                   pick;
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      id;
    logic [OUT_REF_W-1:0] obj_ref;
    pick    = $urandom_range(0, 99);
    obj_ref = $urandom;
    if ($urandom_range(0, 99) < 75) id = sb.pick_live_id();
    else id = ID_W'($urandom_range(0, TABLE_SIZE - 1));
    if (pick < 25) begin
      op = OP_ADD;
      if ($urandom_range(0, 11) == 0) obj_ref = '0;
    end else if (pick < 45) begin
      op = OP_REMOVE;
    end else if (pick < 95) begin
      op = OP_GET;
    end else begin
      op = OP_UNKNOWN;
    end
    send_request(op, id, obj_ref);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_request();
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = '0;
    in_tdata       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    cycles         = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, rejects, first adds, no reuse of freed numbers
    send_request(OP_GET,     8'h00, 32'h0000_0000);  // number zero is never handed out
    send_request(OP_REMOVE,  8'h00, 32'hFFFF_FFFF);
    send_request(OP_ADD,     8'hFF, 32'h0000_0000);  // null reference
    send_request(OP_UNKNOWN, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_ADD,     8'h00, 32'hFFFF_FFFF);  // gets number one
    send_request(OP_ADD,     8'hAA, 32'h0000_0001);
    send_request(OP_ADD,     8'h55, 32'h8000_0000);
    send_request(OP_GET,     8'h01, 32'h0000_0000);
    send_request(OP_GET,     8'h02, 32'hFFFF_FFFF);
    send_request(OP_GET,     8'h03, 32'h0000_0000);
    send_request(OP_GET,     8'hFF, 32'h0000_0000);  // top number, not in use
    send_request(OP_REMOVE,  8'h02, 32'h0000_0000);
    send_request(OP_REMOVE,  8'h02, 32'h0000_0000);  // second free of the same number
    send_request(OP_GET,     8'h02, 32'h0000_0000);  // stale entry reads as invalid
    send_request(OP_ADD,     8'h02, 32'h5A5A_A5A5);  // must skip to four, not reuse two
    send_request(OP_GET,     8'h04, 32'h0000_0000);
    send_request(OP_REMOVE,  8'hFF, 32'h0000_0000);
    send_request(OP_UNKNOWN, 8'h00, 32'h0000_0000);
    send_request(OP_GET,     8'h01, 32'h0000_0000);

    // random traffic under different idling mixes
    run_phase(300, 0, 0);
    run_phase(300, 64, 0);

    // long receiver stall while requests keep coming, so the input backs up
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    run_phase(80, 0, 0);

    run_phase(300, 0, 64);
    run_phase(300, 36, 36);

    in_tvalid      = 1'b0;
    recv_stall_pct = 0;
    while (sb.depth() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.depth() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
